// ===== design/bmc_pkg.sv =====
// Shared types, operation codes and defaults for the bitset membership unit.
package bmc_pkg;

  localparam int CAPACITY_DEF = 4096;
  localparam int WORD_W       = 64;
  localparam int BIT_IDX_W    = 6;
  localparam int ELEM_W       = 12;
  localparam int COUNT_W      = 13;
  localparam int ADD_W        = 7;

  localparam logic [1:0] FN_ADD      = 2'd0;
  localparam logic [1:0] FN_REMOVE   = 2'd1;
  localparam logic [1:0] FN_CONTAINS = 2'd2;
  localparam logic [1:0] FN_UNION    = 2'd3;

  typedef struct packed {
    logic [1:0]           func;
    logic [ELEM_W-1:0]    elem;
    logic [BIT_IDX_W-1:0] word_index;
    logic [WORD_W-1:0]    other_word;
  } in_t;

  typedef struct packed {
    logic               was_member;
    logic [COUNT_W-1:0] set_size;
  } out_t;

  typedef struct packed {
    logic [1:0]           func;
    logic                 hit;
    logic [BIT_IDX_W-1:0] bit_idx;
    logic [WORD_W-1:0]    other;
  } op_t;

  typedef struct packed {
    logic               wr_en;
    logic [WORD_W-1:0]  wr_word;
    logic               was_member;
    logic [ADD_W-1:0]   add_cnt;
    logic               sub_one;
  } upd_t;

endpackage

// ===== design/bitset_membership_with_count_unit.sv =====
// Top level of the bitset membership unit with running population count.
//
// Channels: in_valid/in_stall/in_data carry one operation per beat (add,
// remove, contains, union word); out_valid/out_stall/out_data return one
// beat per operation with prior membership and the set size afterwards.
// Pipeline: when an input beat is accepted, the synchronous store read and
// the operation are registered; once the pipeline advances again, the
// modified word is written back and the output register is loaded.
// Throughput: one beat per cycle unless a result waits under out_stall.
// A word written in one cycle is forwarded to a read of the same row issued
// in that cycle, so back-to-back items on one word see each other's updates.
// Reset: the store reads as empty at once (per-row valid bits are cleared)
// and the count is zero; there is no clearing pass.
// Stall: while a result waits under out_stall the whole pipeline holds and
// in_stall is raised; no store access happens until the result is taken.
module bitset_membership_with_count_unit
  import bmc_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int WORD_COUNT = (CAPACITY + WORD_W - 1) / WORD_W;
  localparam int MEM_DEPTH  = (WORD_COUNT < 64) ? WORD_COUNT : 64;
  localparam int AW         = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int LAST_BITS  = CAPACITY - (WORD_COUNT - 1) * WORD_W;
  localparam logic [WORD_W-1:0] LAST_MASK =
    (LAST_BITS >= WORD_W) ? {WORD_W{1'b1}} : ((WORD_W'(1) << LAST_BITS) - WORD_W'(1));

  logic              adv;
  logic              take;
  logic              is_union;
  logic [BIT_IDX_W-1:0] word_sel;
  logic [AW-1:0]     rd_addr;
  op_t               op_nxt;
  logic [WORD_W-1:0] old_word;
  upd_t              upd;

  logic               s1_vld_r;
  op_t                s1_r;
  logic [AW-1:0]      s1_addr_r;
  logic               out_vld_r;
  logic               was_r;
  logic [COUNT_W-1:0] count_r;

  assign adv      = !(out_vld_r && out_stall);
  assign in_stall = !adv;
  assign take     = in_valid && adv;

  always_comb begin
    is_union       = (in_data.func == FN_UNION);
    word_sel       = is_union ? in_data.word_index : in_data.elem[ELEM_W-1:BIT_IDX_W];
    rd_addr        = word_sel[AW-1:0];
    op_nxt.func    = in_data.func;
    op_nxt.bit_idx = in_data.elem[BIT_IDX_W-1:0];
    op_nxt.hit     = is_union ? (32'(in_data.word_index) < WORD_COUNT)
                              : (32'(in_data.elem) < CAPACITY);
    op_nxt.other   = (32'(in_data.word_index) == WORD_COUNT - 1)
                   ? (in_data.other_word & LAST_MASK) : in_data.other_word;
  end

  bmc_store #(
    .AW(AW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (take),
    .rd_addr (rd_addr),
    .wr_en   (s1_vld_r && adv && upd.wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (upd.wr_word),
    .rd_data (old_word)
  );

  bmc_update u_update (
    .op       (s1_r),
    .old_word (old_word),
    .upd      (upd)
  );

  always_ff @(posedge clk) begin
    if (take) begin
      s1_r      <= op_nxt;
      s1_addr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      was_r     <= 1'b0;
      count_r   <= '0;
    end else if (adv) begin
      s1_vld_r  <= in_valid;
      out_vld_r <= s1_vld_r;
      if (s1_vld_r) begin
        was_r   <= upd.was_member;
        count_r <= count_r + COUNT_W'(upd.add_cnt) - COUNT_W'(upd.sub_one);
      end
    end
  end

  assign out_valid           = out_vld_r;
  assign out_data.was_member = was_r;
  assign out_data.set_size   = count_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= CAPACITY)
    else $error("member count beyond capacity");

  a_contains_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && adv && (s1_r.func == FN_CONTAINS) |=> count_r == $past(count_r))
    else $error("contains changed the count");

  a_remove_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && adv && upd.sub_one |-> count_r != '0)
    else $error("remove of a member with empty count");

endmodule

// ===== design/bmc_store.sv =====
// Word store with per-row valid bits and write-to-read forwarding.
module bmc_store
  import bmc_pkg::*;
#(
  parameter int AW = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  output logic [WORD_W-1:0] rd_data
);

  localparam int ROWS = 1 << AW;

  logic [WORD_W-1:0] mem [ROWS];
  logic [ROWS-1:0]   row_vld_r;
  logic [WORD_W-1:0] rd_q_r;
  logic              rd_vld_r;
  logic              fwd_hit_r;
  logic [WORD_W-1:0] fwd_word_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      fwd_word_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r  <= row_vld_r[rd_addr];
        fwd_hit_r <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  assign rd_data = fwd_hit_r ? fwd_word_r : (rd_vld_r ? rd_q_r : '0);

endmodule

// ===== design/bmc_update.sv =====
// Modify step: new word, prior membership and count change for one operation.
module bmc_update
  import bmc_pkg::*;
(
  input  op_t               op,
  input  logic [WORD_W-1:0] old_word,
  output upd_t              upd
);

  logic [WORD_W-1:0] bit_mask;
  logic [WORD_W-1:0] fresh;
  logic              was;

  always_comb begin
    bit_mask = WORD_W'(1) << op.bit_idx;
    fresh    = op.other & ~old_word;
    was      = op.hit && (op.func != FN_UNION) && old_word[op.bit_idx];
    upd            = '0;
    upd.was_member = was;
    upd.wr_word    = old_word;
    case (op.func)
      FN_ADD: begin
        upd.wr_en   = op.hit && !was;
        upd.wr_word = old_word | bit_mask;
        upd.add_cnt = ADD_W'(op.hit && !was);
      end
      FN_REMOVE: begin
        upd.wr_en   = was;
        upd.wr_word = old_word & ~bit_mask;
        upd.sub_one = was;
      end
      FN_UNION: begin
        upd.wr_en   = op.hit;
        upd.wr_word = old_word | op.other;
        upd.add_cnt = op.hit ? ADD_W'($countones(fresh)) : '0;
      end
      default: begin
        upd.wr_en = 1'b0;
      end
    endcase
  end

endmodule

// ===== tb/sv/bmc_membership_checker.sv =====
// Result checker for the bitset membership unit: tracks the set and compares every result beat.
module bmc_membership_checker
  import bmc_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_stall,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_stall,
  input  out_t out_data,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORDS = (CAPACITY + WORD_W - 1) / WORD_W;

  logic [WORD_W-1:0]  set_words [WORDS];
  logic [COUNT_W-1:0] set_size;
  out_t               due_results [$];
  int                 errs = 0;

  assign fail_count = errs;

  function automatic logic [WORD_W-1:0] live_bits(int wi);
    int left;
    left = CAPACITY - wi * WORD_W;
    if (left >= WORD_W) return '1;
    return (64'd1 << left) - 64'd1;
  endfunction

  function automatic out_t step_membership(in_t op);
    out_t              r;
    logic [WORD_W-1:0] old_w;
    logic [WORD_W-1:0] merged;
    int                w;
    r.was_member = 1'b0;
    if (op.func == FN_UNION) begin
      if (int'(op.word_index) < WORDS) begin
        old_w = set_words[op.word_index];
        merged = old_w | (op.other_word & live_bits(int'(op.word_index)));
        set_words[op.word_index] = merged;
        set_size = set_size + COUNT_W'($countones(merged) - $countones(old_w));
      end
    end else if (int'(op.elem) < CAPACITY) begin
      w = int'(op.elem >> BIT_IDX_W);
      r.was_member = set_words[w][op.elem[BIT_IDX_W-1:0]];
      if (op.func == FN_ADD && !r.was_member) begin
        set_words[w][op.elem[BIT_IDX_W-1:0]] = 1'b1;
        set_size = set_size + COUNT_W'(1);
      end else if (op.func == FN_REMOVE && r.was_member) begin
        set_words[w][op.elem[BIT_IDX_W-1:0]] = 1'b0;
        set_size = set_size - COUNT_W'(1);
      end
    end
    r.set_size = set_size;
    return r;
  endfunction

  task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    errs++;
    $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      foreach (set_words[i]) set_words[i] = '0;
      set_size = '0;
      due_results.delete();
    end else begin
      if (in_valid && !in_stall) due_results.push_back(step_membership(in_data));
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          errs++;
          $display("%0t ns: unexpected result beat, expected none actual %0d/%0d",
                   $time, out_data.was_member, out_data.set_size);
        end else begin
          want = due_results.pop_front();
          if (out_data.was_member !== want.was_member) begin
            note_mismatch("was_member", 32'(want.was_member), 32'(out_data.was_member));
          end
          if (out_data.set_size !== want.set_size) begin
            note_mismatch("set_size", 32'(want.set_size), 32'(out_data.set_size));
          end
        end
      end
    end
    pending <= due_results.size();
  end

endmodule

// ===== tb/sv/bitset_membership_with_count_unit_test.sv =====
// Testbench top for the bitset membership unit: clock, reset, stimulus and verdict.
module bitset_membership_with_count_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bmc_pkg::*;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  int   fail_count;
  int   pending;

  int   sent;
  bit   tx_calm;
  bit   rx_calm;
  bit   rx_hold_req;

  always #6 clk = ~clk;

  bitset_membership_with_count_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  bmc_membership_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic logic [WORD_W-1:0] random_word();
    logic [WORD_W-1:0] w;
    case ($urandom_range(0, 4))
      0: w = {$urandom, $urandom};
      1: w = 64'd1 << $urandom_range(0, 63);
      2: w = '1;
      3: w = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      default: w = ~(64'd1 << $urandom_range(0, 63));
    endcase
    return w;
  endfunction

  function automatic in_t op_item(logic [1:0] f, logic [ELEM_W-1:0] e,
                                  logic [BIT_IDX_W-1:0] wi, logic [WORD_W-1:0] ow);
    in_t b;
    b.func       = f;
    b.elem       = e;
    b.word_index = wi;
    b.other_word = ow;
    if (f == FN_UNION) begin
      b.elem = ELEM_W'($urandom);
    end else begin
      b.word_index = BIT_IDX_W'($urandom);
      b.other_word = {$urandom, $urandom};
    end
    return b;
  endfunction

  function automatic in_t random_item();
    return op_item(2'($urandom_range(0, 3)), ELEM_W'($urandom_range(0, 4095)),
                   BIT_IDX_W'($urandom_range(0, 63)), random_word());
  endfunction

  task automatic push_beat(input in_t b);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : result_sink
    int gap;
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end else begin
        gap = rx_calm ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int kind;
    int n;
    int w;
    bit held;
    bit paused;
    in_valid <= 1'b0;
    in_data  <= '0;
    rst_n    <= 1'b0;
    held = 1'b0;
    paused = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    push_beat(op_item(FN_CONTAINS, 12'd0, '0, '0));
    push_beat(op_item(FN_ADD, 12'd0, '0, '0));
    push_beat(op_item(FN_ADD, 12'd0, '0, '0));
    push_beat(op_item(FN_CONTAINS, 12'd0, '0, '0));
    push_beat(op_item(FN_ADD, 12'd4095, '0, '0));
    push_beat(op_item(FN_CONTAINS, 12'd4095, '0, '0));
    push_beat(op_item(FN_REMOVE, 12'd4095, '0, '0));
    push_beat(op_item(FN_REMOVE, 12'd4095, '0, '0));
    push_beat(op_item(FN_CONTAINS, 12'd4095, '0, '0));
    push_beat(op_item(FN_ADD, 12'hAAA, '0, '0));
    push_beat(op_item(FN_ADD, 12'h555, '0, '0));
    push_beat(op_item(FN_UNION, '0, 6'd0, '1));
    push_beat(op_item(FN_UNION, '0, 6'd0, '0));
    push_beat(op_item(FN_UNION, '0, 6'd63, 64'h8000_0000_0000_0000));
    push_beat(op_item(FN_UNION, '0, 6'd63, '1));
    push_beat(op_item(FN_REMOVE, 12'd4032, '0, '0));
    push_beat(op_item(FN_CONTAINS, 12'd4032, '0, '0));
    push_beat(op_item(FN_UNION, '0, 6'd42, 64'hAAAA_AAAA_AAAA_AAAA));
    push_beat(op_item(FN_UNION, '0, 6'd21, 64'h5555_5555_5555_5555));
    push_beat(op_item(FN_REMOVE, 12'd0, '0, '0));
    push_beat(op_item(FN_ADD, 12'd64, '0, '0));
    push_beat(op_item(FN_CONTAINS, 12'd63, '0, '0));

    while (sent < 1100) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if (!held && sent >= 350) begin
        held = 1'b1;
        tx_calm = 1'b1;
        rx_hold_req = 1'b1;
        repeat (40) push_beat(random_item());
      end
      if (!paused && sent >= 700) begin
        paused = 1'b1;
        drain();
      end
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        w = $urandom_range(0, 63);
        n = $urandom_range(4, 10);
        repeat (n) begin
          push_beat(op_item(2'($urandom_range(0, 3)),
                            {w[5:0], 6'($urandom_range(0, 7))}, w[5:0], random_word()));
        end
      end else if (kind < 90) begin
        push_beat(random_item());
      end else if (kind < 92) begin
        for (int i = 0; i < 64; i++) begin
          push_beat(op_item(FN_UNION, '0, BIT_IDX_W'(i), random_word()));
        end
      end else begin
        w = $urandom_range(0, 63);
        repeat (12) begin
          push_beat(op_item(2'($urandom_range(0, 1)) == 2'd0 ? FN_REMOVE : FN_ADD,
                            {w[5:0], 6'($urandom_range(0, 63))}, '0, '0));
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== bitset_membership_with_count_unit.f =====
design/bmc_pkg.sv
design/bmc_store.sv
design/bmc_update.sv
design/bitset_membership_with_count_unit.sv
tb/sv/bmc_membership_checker.sv
tb/sv/bitset_membership_with_count_unit_test.sv
